// ===== sv/wsi_pkg.sv =====
// Shared types, constants and helpers for the wheel spin integrator.
// Depends on nothing; imported by wsi_seq, wsi_mul, wheel_spin_integrator_core and tb_top.

package wsi_pkg;

    // Widths of the configuration port and of the shared multiplier.
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 31;
    localparam int OP_A_W    = 33;
    localparam int OP_B_W    = 31;
    localparam int PROD_W    = OP_A_W + OP_B_W;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BRAKE_CAP   = 3'd0,
        CFG_BRAKE_DECEL = 3'd1,
        CFG_FREEWHEEL   = 3'd2,
        CFG_SPIN_LIMIT  = 3'd3,
        CFG_SLOW_SPIN   = 3'd4
    } cfg_index_t;

    // Register values after reset (Q16.16).
    localparam logic [CFG_W-1:0] BRAKE_CAP_RST   = 31'd6553600;
    localparam logic [CFG_W-1:0] BRAKE_DECEL_RST = 31'd65536000;
    localparam logic [CFG_W-1:0] FREEWHEEL_RST   = 31'd32768000;
    localparam logic [CFG_W-1:0] SPIN_LIMIT_RST  = 31'd589824000;
    localparam logic [CFG_W-1:0] SLOW_SPIN_RST   = 31'd6553600;

    // Sequencer state.
    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } seq_state_t;

    // A step per cycle, but STEP_RESULT may stall; each product is stored a step later.
    typedef enum logic [3:0] {
        STEP_TORQUE_DT = 4'd0,
        STEP_DECEL     = 4'd1,
        STEP_DELTA     = 4'd2,
        STEP_DROP_DT   = 4'd3,
        STEP_CAPACITY  = 4'd4,
        STEP_DROP      = 4'd5,
        STEP_MOMENTUM  = 4'd6,
        STEP_KEEP      = 4'd7,
        STEP_RESULT    = 4'd8
    } step_t;

    // Control from the sequencer to the datapath.
    typedef struct packed {
        logic  run;
        logic  start;
        logic  finish;
        step_t step;
    } seq_ctl_t;

    // Saturate a shifted product at 2^32; anything that large clamps the same way later.
    function automatic logic [32:0] sat_33(input logic [47:0] q);
        if (|q[47:32])
        begin
            return 33'h1_0000_0000;
        end
        return {1'b0, q[31:0]};
    endfunction

    // Saturate a shifted product at 2^31, above any spin magnitude.
    function automatic logic [31:0] sat_32(input logic [47:0] q);
        if (|q[47:31])
        begin
            return 32'h8000_0000;
        end
        return {1'b0, q[30:0]};
    endfunction

endpackage

// ===== sv/wsi_mul.sv =====
// Shared unsigned multiplier with a registered product.
// Depends on wsi_pkg for the operand and product widths.

module wsi_mul (
    input  logic                        clk,
    input  logic [wsi_pkg::OP_A_W-1:0]  op_a,
    input  logic [wsi_pkg::OP_B_W-1:0]  op_b,
    output logic [wsi_pkg::PROD_W-1:0]  prod_reg
);
    import wsi_pkg::*;

    // Full-width product, registered before anything uses it.
    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

endmodule

// ===== sv/wsi_seq.sv =====
// Sequencer that walks one frame through the steps of the shared multiplier.
// Depends on wsi_pkg for the state, step and control types.

module wsi_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              out_free,
    output logic              in_ready,
    output wsi_pkg::seq_ctl_t ctl
);
    import wsi_pkg::*;

    seq_state_t state_reg, state_next;
    step_t      step_reg, step_next;

    // State and step registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
            step_reg  <= STEP_TORQUE_DT;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Next state and control outputs.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        in_ready   = 1'b0;
        ctl.run    = (state_reg == SEQ_RUN);
        ctl.start  = 1'b0;
        ctl.finish = 1'b0;
        ctl.step   = step_reg;
        unique case (state_reg)
            SEQ_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.start  = 1'b1;
                    state_next = SEQ_RUN;
                    step_next  = STEP_TORQUE_DT;
                end
            end
            SEQ_RUN:
            begin
                if (step_reg == STEP_RESULT)
                begin
                    // The result waits here until the output register is free.
                    if (out_free)
                    begin
                        ctl.finish = 1'b1;
                        state_next = SEQ_IDLE;
                    end
                end
                else
                begin
                    step_next = step_t'(step_reg + 4'd1);
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/wheel_spin_integrator_core.sv =====
// Top level of the wheel spin integrator: configuration registers, datapath, result register.
// Depends on wsi_pkg, wsi_seq and wsi_mul.
//
// Usage:
//   The input channel (in_valid/in_ready) takes one request per wheel frame, with its
//   time step, torque, inertias, brake factor, rev limit and the gas, reverse and
//   locked flags. The output channel (out_valid/out_ready) returns one result per
//   request: the new spin, inertia_kept and spin_kept.
//   The configuration channel (cfg_valid/cfg_ready) is always ready; cfg_index picks
//   one of five registers and cfg_data is written to it. Unused indexes are ignored.
//   Write it only while no request is in flight.
//   A request walks the sequencer steps in order, and out_valid is set as the result step
//   finishes. The seven products of a frame share one multiplier, one product per cycle,
//   and a frame starts only when the previous one has left the sequencer, so a new
//   request is not taken before the last one is through.
//   Reset clears the stored spin to zero and loads the register defaults.
//   When the receiver stalls, the result stays in the output register; the next
//   request is accepted and worked on, and waits in its last step until the
//   output register is free.

module wheel_spin_integrator_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [16:0]                    time_step,
    input  logic signed [31:0]             drive_torque,
    input  logic [30:0]                    wheel_inertia,
    input  logic [30:0]                    inverse_inertia,
    input  logic [16:0]                    brake_amount,
    input  logic signed [31:0]             rev_limit,
    input  logic                           gas_released,
    input  logic                           reverse_gear,
    input  logic                           wheel_locked,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [31:0]             new_spin,
    output logic                           inertia_kept,
    output logic                           spin_kept,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [wsi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wsi_pkg::CFG_W-1:0]      cfg_data
);
    import wsi_pkg::*;

    // Configuration registers.
    logic [CFG_W-1:0] bcap_reg, bdecel_reg, freewheel_reg, slimit_reg, slow_reg;

    // Captured request fields.
    logic [16:0]        dt_reg;
    logic signed [31:0] torque_reg;
    logic [30:0]        inertia_reg;
    logic [30:0]        inv_reg;
    logic [16:0]        brake_reg;
    logic signed [31:0] rev_reg;
    logic               gas_reg;
    logic               reverse_reg;
    logic               locked_reg;

    // Intermediate results of the step sequence.
    logic [31:0] m1_reg;
    logic [31:0] decel_reg;
    logic [32:0] dmag_reg;
    logic [32:0] e1_reg;
    logic [30:0] amag_reg;
    logic        neg_reg;
    logic [31:0] cap_reg;
    logic [31:0] drop_reg;
    logic        keep_spin_reg;
    logic        keep_inertia_reg;
    logic [30:0] slowed_reg;

    // Stored spin and the result register.
    logic signed [31:0] spin_rate_reg;
    logic               out_valid_reg;
    logic signed [31:0] new_spin_reg;
    logic               inertia_kept_reg;
    logic               spin_kept_reg;

    // Datapath wiring.
    seq_ctl_t            ctl;
    logic                out_free;
    logic [OP_A_W-1:0]   op_a;
    logic [OP_B_W-1:0]   op_b;
    logic [PROD_W-1:0]   prod_reg;
    logic [47:0]         prod_q;
    logic [31:0]         tmag;
    logic [31:0]         decel_sel;
    logic signed [34:0]  cand;
    logic signed [34:0]  delta;
    logic signed [34:0]  lim35;
    logic signed [34:0]  mag35;
    logic [30:0]         cand_amag;
    logic                cand_neg;
    logic [32:0]         momentum;
    logic                keep_spin_c;
    logic                keep_inertia_c;
    logic [30:0]         slowed_c;
    logic signed [31:0]  result_c;

    assign cfg_ready    = 1'b1;
    assign out_free     = !out_valid_reg || out_ready;
    assign out_valid    = out_valid_reg;
    assign new_spin     = new_spin_reg;
    assign inertia_kept = inertia_kept_reg;
    assign spin_kept    = spin_kept_reg;

    // Sequencer.
    wsi_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_free (out_free),
        .in_ready (in_ready),
        .ctl      (ctl)
    );

    // Shared multiplier.
    wsi_mul u_mul (
        .clk      (clk),
        .op_a     (op_a),
        .op_b     (op_b),
        .prod_reg (prod_reg)
    );

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bcap_reg      <= BRAKE_CAP_RST;
            bdecel_reg    <= BRAKE_DECEL_RST;
            freewheel_reg <= FREEWHEEL_RST;
            slimit_reg    <= SPIN_LIMIT_RST;
            slow_reg      <= SLOW_SPIN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_BRAKE_CAP:   bcap_reg      <= cfg_data;
                CFG_BRAKE_DECEL: bdecel_reg    <= cfg_data;
                CFG_FREEWHEEL:   freewheel_reg <= cfg_data;
                CFG_SPIN_LIMIT:  slimit_reg    <= cfg_data;
                CFG_SLOW_SPIN:   slow_reg      <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Capture the request when it is accepted.
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            dt_reg      <= time_step;
            torque_reg  <= drive_torque;
            inertia_reg <= wheel_inertia;
            inv_reg     <= inverse_inertia;
            brake_reg   <= brake_amount;
            rev_reg     <= rev_limit;
            gas_reg     <= gas_released;
            reverse_reg <= reverse_gear;
            locked_reg  <= wheel_locked;
        end
    end

    // Torque magnitude; the most negative torque gives exactly 2^31.
    assign tmag   = torque_reg[31] ? (~torque_reg + 32'd1) : torque_reg;
    assign prod_q = prod_reg[63:16];

    // Operand selection for the product issued in each step.
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        unique case (ctl.step)
            STEP_TORQUE_DT:
            begin
                op_a = {1'b0, tmag};
                op_b = {14'd0, dt_reg};
            end
            STEP_DECEL:
            begin
                op_a = {2'b0, bdecel_reg};
                op_b = {14'd0, brake_reg};
            end
            STEP_DELTA:
            begin
                op_a = {1'b0, m1_reg};
                op_b = inv_reg;
            end
            STEP_DROP_DT:
            begin
                op_a = {1'b0, decel_reg};
                op_b = {14'd0, dt_reg};
            end
            STEP_CAPACITY:
            begin
                op_a = {2'b0, bcap_reg};
                op_b = {14'd0, brake_reg};
            end
            STEP_DROP:
            begin
                op_a = e1_reg;
                op_b = inv_reg;
            end
            STEP_MOMENTUM:
            begin
                op_a = {2'b0, amag_reg};
                op_b = inertia_reg;
            end
            STEP_KEEP, STEP_RESULT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Deceleration: brake when braking, drag when the gas is released, else none.
    always_comb
    begin
        if (brake_reg != 17'd0)
        begin
            decel_sel = prod_q[31:0];
        end
        else if (gas_reg)
        begin
            decel_sel = {1'b0, freewheel_reg};
        end
        else
        begin
            decel_sel = '0;
        end
    end

    // Candidate spin: stored spin plus the signed increment, clamped to the spin limit.
    always_comb
    begin
        delta = torque_reg[31] ? -$signed({2'b0, dmag_reg}) : $signed({2'b0, dmag_reg});
        cand  = $signed({{3{spin_rate_reg[31]}}, spin_rate_reg}) + delta;
        lim35 = $signed({4'b0, slimit_reg});
        mag35 = cand[34] ? -cand : cand;
        if (cand > lim35)
        begin
            cand_amag = slimit_reg;
            cand_neg  = 1'b0;
        end
        else if (cand < -lim35)
        begin
            cand_amag = slimit_reg;
            cand_neg  = 1'b1;
        end
        else
        begin
            cand_amag = mag35[30:0];
            cand_neg  = cand[34];
        end
    end

    // Momentum against brake capacity, and the spin slowed without crossing zero.
    assign momentum       = sat_33(prod_q);
    assign keep_spin_c    = momentum > {1'b0, cap_reg};
    assign keep_inertia_c = keep_spin_c || (amag_reg < slow_reg);
    assign slowed_c       = ({1'b0, amag_reg} > drop_reg) ? (amag_reg - drop_reg[30:0]) : '0;

    // Sign (zero when the spin is not kept), forward-gear floor, rev limit and lock.
    always_comb
    begin
        if (keep_spin_reg)
        begin
            result_c = neg_reg ? -$signed({1'b0, slowed_reg}) : $signed({1'b0, slowed_reg});
        end
        else
        begin
            result_c = '0;
        end
        if (!reverse_reg && result_c < 0)
        begin
            result_c = '0;
        end
        if (!rev_reg[31])
        begin
            if (result_c > rev_reg)
            begin
                result_c = rev_reg;
            end
        end
        else if (result_c < rev_reg)
        begin
            result_c = rev_reg;
        end
        if (locked_reg)
        begin
            result_c = '0;
        end
    end

    // Store each product as it leaves the multiplier, one step behind its issue.
    always_ff @(posedge clk)
    begin
        if (ctl.run)
        begin
            unique case (ctl.step)
                STEP_DECEL:
                begin
                    m1_reg <= prod_q[31:0];
                end
                STEP_DELTA:
                begin
                    decel_reg <= decel_sel;
                end
                STEP_DROP_DT:
                begin
                    dmag_reg <= sat_33(prod_q);
                end
                STEP_CAPACITY:
                begin
                    e1_reg   <= prod_q[32:0];
                    amag_reg <= cand_amag;
                    neg_reg  <= cand_neg;
                end
                STEP_DROP:
                begin
                    cap_reg <= prod_q[31:0];
                end
                STEP_MOMENTUM:
                begin
                    drop_reg <= sat_32(prod_q);
                end
                STEP_KEEP:
                begin
                    keep_spin_reg    <= keep_spin_c;
                    keep_inertia_reg <= keep_inertia_c;
                    slowed_reg       <= slowed_c;
                end
                STEP_TORQUE_DT, STEP_RESULT:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    // Stored spin and output handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spin_rate_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (ctl.finish)
        begin
            spin_rate_reg <= result_c;
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (ctl.finish)
        begin
            new_spin_reg     <= result_c;
            inertia_kept_reg <= keep_inertia_reg;
            spin_kept_reg    <= keep_spin_reg;
        end
    end

`ifndef SYNTH
    // The block takes one request at a time.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while another is in flight");

    // A wheel that did not keep its spin reports zero.
    a_stopped_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !spin_kept |-> new_spin == 32'sd0)
        else $error("stopped wheel reports non-zero spin");

    // Kept spin always keeps the inertia.
    a_keep_inertia: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && spin_kept |-> inertia_kept)
        else $error("spin kept but inertia dropped");

    // A locked wheel gives zero on its fresh result.
    a_locked_zero: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) && locked_reg |-> new_spin == 32'sd0)
        else $error("locked wheel reports non-zero spin");
`endif

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for wheel_spin_integrator_core: directed frames, then random frames
// under five register settings, each result checked against an in-bench spin predictor or a typed-in value.
// Depends on wsi_pkg and the wheel_spin_integrator_core RTL.

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import wsi_pkg::*;

    localparam int  CYCLE_LIMIT     = 400000;
    localparam int  FRAMES_PER_SET  = 190;
    localparam int  NUM_SETTINGS    = 5;
    localparam int  DRAIN_CYCLES    = 12;
    localparam longint unsigned MAG_SAT = 64'd1 << 40;
    localparam logic [30:0] REG_MAX = 31'h7FFF_FFFF;

    // One wheel frame as carried by the input request.
    typedef struct {
        logic [16:0]        time_step;
        logic signed [31:0] drive_torque;
        logic [30:0]        wheel_inertia;
        logic [30:0]        inverse_inertia;
        logic [16:0]        brake_amount;
        logic signed [31:0] rev_limit;
        logic               gas_released;
        logic               reverse_gear;
        logic               wheel_locked;
    } wheel_frame_t;

    // One result of the output channel.
    typedef struct {
        logic signed [31:0] new_spin;
        logic               inertia_kept;
        logic               spin_kept;
    } spin_result_t;

    // A directed row; the result is typed in only where it is obvious.
    typedef struct {
        wheel_frame_t frm;
        bit           typed;
        spin_result_t want;
    } directed_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [16:0]        time_step = '0;
    logic signed [31:0] drive_torque = '0;
    logic [30:0]        wheel_inertia = '0;
    logic [30:0]        inverse_inertia = '0;
    logic [16:0]        brake_amount = '0;
    logic signed [31:0] rev_limit = '0;
    logic               gas_released = 1'b0;
    logic               reverse_gear = 1'b0;
    logic               wheel_locked = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] new_spin;
    logic               inertia_kept;
    logic               spin_kept;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]   cfg_data = '0;

    // Predictor copy of the registers and the stored spin.
    logic [30:0]        brake_cap_q   = BRAKE_CAP_RST;
    logic [30:0]        brake_decel_q = BRAKE_DECEL_RST;
    logic [30:0]        freewheel_q   = FREEWHEEL_RST;
    logic [30:0]        spin_limit_q  = SPIN_LIMIT_RST;
    logic [30:0]        slow_spin_q   = SLOW_SPIN_RST;
    logic signed [31:0] spin_state    = '0;

    spin_result_t       spin_results_due[$];
    directed_row_t      plan[$];
    bit                 calm = 1'b0;
    int                 failures = 0;
    int                 frames_sent = 0;
    int                 results_checked = 0;
    int                 reg_writes = 0;
    int                 cycles = 0;

    wheel_spin_integrator_core u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .time_step       (time_step),
        .drive_torque    (drive_torque),
        .wheel_inertia   (wheel_inertia),
        .inverse_inertia (inverse_inertia),
        .brake_amount    (brake_amount),
        .rev_limit       (rev_limit),
        .gas_released    (gas_released),
        .reverse_gear    (reverse_gear),
        .wheel_locked    (wheel_locked),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .new_spin        (new_spin),
        .inertia_kept    (inertia_kept),
        .spin_kept       (spin_kept),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run watchdog.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    // Fixed-point product of two magnitudes, shifted by 16 and saturated at 2^40.
    function automatic longint unsigned fixed_mul(input longint unsigned a,
                                                  input longint unsigned b);
        longint unsigned wa;
        longint unsigned wb;
        logic [95:0]     p;
        wa = (a > MAG_SAT) ? MAG_SAT : a;
        wb = (b > MAG_SAT) ? MAG_SAT : b;
        p  = ({32'd0, wa} * {32'd0, wb}) >> 16;
        if (p > MAG_SAT)
        begin
            return MAG_SAT;
        end
        return p[63:0];
    endfunction

    // Advance the predicted wheel by one frame and return its result.
    function automatic spin_result_t integrate_frame(input wheel_frame_t f);
        longint          torque;
        longint          rev;
        longint          lim;
        longint          cand;
        longint          res;
        longint unsigned tmag;
        longint unsigned dmag;
        longint unsigned amag;
        longint unsigned momentum;
        longint unsigned capacity;
        longint unsigned decel;
        longint unsigned drop;
        longint unsigned slowed;
        bit              keep_spin;
        spin_result_t    r;
        torque = f.drive_torque;
        rev    = f.rev_limit;
        lim    = longint'({33'd0, spin_limit_q});

        // Torque impulse, then the hard clamp.
        tmag = (torque < 0) ? longint'(-torque) : longint'(torque);
        dmag = fixed_mul(fixed_mul(tmag, {47'd0, f.time_step}), {33'd0, f.inverse_inertia});
        cand = longint'(spin_state) + ((torque < 0) ? -longint'(dmag) : longint'(dmag));
        if (cand > lim)
        begin
            cand = lim;
        end
        if (cand < -lim)
        begin
            cand = -lim;
        end
        amag = (cand < 0) ? longint'(-cand) : longint'(cand);

        // The wheel stops dead when the brakes can absorb its momentum.
        momentum  = fixed_mul(amag, {33'd0, f.wheel_inertia});
        capacity  = fixed_mul({47'd0, f.brake_amount}, {33'd0, brake_cap_q});
        keep_spin = momentum > capacity;

        // Brake or freewheel deceleration towards zero, never across it.
        if (f.brake_amount != '0)
        begin
            decel = fixed_mul({33'd0, brake_decel_q}, {47'd0, f.brake_amount});
        end
        else
        begin
            decel = f.gas_released ? {33'd0, freewheel_q} : 64'd0;
        end
        drop   = fixed_mul(fixed_mul(decel, {47'd0, f.time_step}), {33'd0, f.inverse_inertia});
        slowed = (amag > drop) ? amag - drop : 64'd0;

        // Gear, rev limit and lock.
        if (!keep_spin || cand == 0)
        begin
            res = 0;
        end
        else
        begin
            res = (cand > 0) ? longint'(slowed) : -longint'(slowed);
        end
        if (!f.reverse_gear && res < 0)
        begin
            res = 0;
        end
        if (rev >= 0)
        begin
            if (res > rev)
            begin
                res = rev;
            end
        end
        else if (res < rev)
        begin
            res = rev;
        end
        if (f.wheel_locked)
        begin
            res = 0;
        end

        spin_state     = res[31:0];
        r.new_spin     = res[31:0];
        r.inertia_kept = keep_spin || (amag < {33'd0, slow_spin_q});
        r.spin_kept    = keep_spin;
        return r;
    endfunction

    function automatic wheel_frame_t make_frame(input logic [16:0] dt,
                                                input logic signed [31:0] torque,
                                                input logic [30:0] inertia,
                                                input logic [30:0] inv_inertia,
                                                input logic [16:0] brake,
                                                input logic signed [31:0] rev,
                                                input logic gas, input logic rvs,
                                                input logic lck);
        wheel_frame_t f;
        f.time_step       = dt;
        f.drive_torque    = torque;
        f.wheel_inertia   = inertia;
        f.inverse_inertia = inv_inertia;
        f.brake_amount    = brake;
        f.rev_limit       = rev;
        f.gas_released    = gas;
        f.reverse_gear    = rvs;
        f.wheel_locked    = lck;
        return f;
    endfunction

    // Mostly plausible driving frames, the rest raw bit patterns.
    function automatic wheel_frame_t random_frame();
        wheel_frame_t f;
        if ($urandom_range(99) < 65)
        begin
            f.time_step     = ($urandom_range(4) == 0) ? 17'd65536 : 17'($urandom_range(400, 4400));
            f.drive_torque  = $urandom_range(0, 1 << 26);
            if ($urandom_range(1))
            begin
                f.drive_torque = -f.drive_torque;
            end
            f.wheel_inertia   = 31'($urandom_range(6554, 655360));
            f.inverse_inertia = 31'(32'hFFFF_FFFF / f.wheel_inertia);
            if ($urandom_range(19) == 0)
            begin
                f.wheel_inertia   = '0;
                f.inverse_inertia = '0;
            end
            f.brake_amount  = $urandom_range(1) ? 17'd0 : 17'($urandom_range(0, 65536));
            f.gas_released  = 1'($urandom_range(1));
            f.reverse_gear  = ($urandom_range(9) < 3);
            f.wheel_locked  = ($urandom_range(19) == 0);
            f.rev_limit     = $urandom_range(1 << 20, 1 << 30);
            if (f.reverse_gear)
            begin
                f.rev_limit = -f.rev_limit;
            end
        end
        else
        begin
            f.time_step       = 17'($urandom);
            f.drive_torque    = $urandom;
            f.wheel_inertia   = 31'($urandom);
            f.inverse_inertia = 31'($urandom);
            f.brake_amount    = 17'($urandom);
            f.rev_limit       = $urandom;
            f.gas_released    = 1'($urandom_range(1));
            f.reverse_gear    = 1'($urandom_range(1));
            f.wheel_locked    = 1'($urandom_range(1));
        end
        return f;
    endfunction

    // Offer one frame request, wait for it to be taken, then record what it should give.
    task automatic send_frame(input wheel_frame_t f, input bit typed, input spin_result_t want);
        spin_result_t predicted;
        while (!calm && $urandom_range(99) < 28)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        time_step       <= f.time_step;
        drive_torque    <= f.drive_torque;
        wheel_inertia   <= f.wheel_inertia;
        inverse_inertia <= f.inverse_inertia;
        brake_amount    <= f.brake_amount;
        rev_limit       <= f.rev_limit;
        gas_released    <= f.gas_released;
        reverse_gear    <= f.reverse_gear;
        wheel_locked    <= f.wheel_locked;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = integrate_frame(f);
        spin_results_due.push_back(typed ? want : predicted);
        frames_sent++;
    endtask

    // One register write request; cfg_valid is left high for a following write.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [30:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_BRAKE_CAP:   brake_cap_q   = val;
            CFG_BRAKE_DECEL: brake_decel_q = val;
            CFG_FREEWHEEL:   freewheel_q   = val;
            CFG_SPIN_LIMIT:  spin_limit_q  = val;
            CFG_SLOW_SPIN:   slow_spin_q   = val;
            default:         ;
        endcase
        reg_writes++;
    endtask

    // Load all five registers, plus one write to an unused index that must be ignored.
    task automatic program_registers(input logic [30:0] cap, input logic [30:0] decel,
                                     input logic [30:0] freewheel, input logic [30:0] limit,
                                     input logic [30:0] slow);
        write_register(CFG_BRAKE_CAP, cap);
        write_register(CFG_BRAKE_DECEL, decel);
        write_register(CFG_FREEWHEEL, freewheel);
        write_register(CFG_SPIN_LIMIT, limit);
        write_register(CFG_SLOW_SPIN, slow);
        write_register(CFG_IDX_W'(CFG_SLOW_SPIN + 1 + $urandom_range(2)), 31'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // Receiver: random back-pressure, and each result compared with the oldest prediction.
    always @(posedge clk)
    begin
        spin_result_t exp_r;
        out_ready <= calm || ($urandom_range(99) >= 28);
        if (rst_n && out_valid && out_ready)
        begin
            if (spin_results_due.size() == 0)
            begin
                $error("unexpected result: new_spin %0d", new_spin);
                failures++;
            end
            else
            begin
                exp_r = spin_results_due.pop_front();
                results_checked++;
                if (new_spin !== exp_r.new_spin)
                begin
                    $error("new_spin: expected %0d, got %0d", exp_r.new_spin, new_spin);
                    failures++;
                end
                if (inertia_kept !== exp_r.inertia_kept)
                begin
                    $error("inertia_kept: expected %0b, got %0b", exp_r.inertia_kept,
                           inertia_kept);
                    failures++;
                end
                if (spin_kept !== exp_r.spin_kept)
                begin
                    $error("spin_kept: expected %0b, got %0b", exp_r.spin_kept, spin_kept);
                    failures++;
                end
            end
        end
    end

    initial
    begin
        // Directed frames, run under the reset register values.
        plan.push_back('{make_frame(17'd0, 32'sd0, 31'd0, 31'd0, 17'd0, 32'sd0, 1'b0, 1'b0, 1'b0),
                         1'b1, '{32'sd0, 1'b1, 1'b0}});
        plan.push_back('{make_frame(17'd65536, 32'h7FFF_FFFF, 31'd65536, 31'd65536, 17'd0,
                                    32'h7FFF_FFFF, 1'b0, 1'b0, 1'b1),
                         1'b1, '{32'sd0, 1'b1, 1'b1}});
        plan.push_back('{make_frame(17'd65536, 32'h7FFF_FFFF, 31'd65536, 31'd65536, 17'd0,
                                    32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0),
                         1'b1, '{32'sd589824000, 1'b1, 1'b1}});
        plan.push_back('{make_frame(17'd65536, 32'h8000_0000, 31'd65536, 31'd65536, 17'd0,
                                    32'h8000_0000, 1'b0, 1'b1, 1'b0),
                         1'b1, '{-32'sd589824000, 1'b1, 1'b1}});
        plan.push_back('{make_frame(17'd65536, 32'h8000_0000, 31'd65536, 31'd65536, 17'd0,
                                    32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0),
                         1'b1, '{32'sd0, 1'b1, 1'b1}});
        // Saturating products: every numeric field at its top bit pattern.
        plan.push_back('{make_frame(17'h1FFFF, 32'h7FFF_FFFF, REG_MAX, REG_MAX, 17'h1FFFF,
                                    32'h7FFF_FFFF, 1'b1, 1'b1, 1'b0), 1'b0, '{default: '0}});
        // Spin up to 100, then freewheel drag with gas released and no brake.
        plan.push_back('{make_frame(17'd65536, 32'sd6553600, 31'd65536, 31'd65536, 17'd0,
                                    32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0), 1'b0, '{default: '0}});
        plan.push_back('{make_frame(17'd1024, 32'sd0, 31'd65536, 31'd65536, 17'd0,
                                    32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0), 1'b0, '{default: '0}});
        // Full brake on a slow wheel stops it dead.
        plan.push_back('{make_frame(17'd1024, 32'sd0, 31'd65536, 31'd65536, 17'd65536,
                                    32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0), 1'b0, '{default: '0}});
        // Positive rev limit caps the spin.
        plan.push_back('{make_frame(17'd65536, 32'sd13107200, 31'd65536, 31'd65536, 17'd0,
                                    32'sd3276800, 1'b0, 1'b0, 1'b0), 1'b0, '{default: '0}});
        // Negative rev limit in reverse bounds the spin from below.
        plan.push_back('{make_frame(17'd65536, -32'sd26214400, 31'd65536, 31'd65536, 17'd0,
                                    -32'sd1310720, 1'b0, 1'b1, 1'b0), 1'b0, '{default: '0}});
        // Zero rev limit, inertia latched off, and a zero time step.
        plan.push_back('{make_frame(17'd65536, 32'sd6553600, 31'd65536, 31'd65536, 17'd0,
                                    32'sd0, 1'b0, 1'b0, 1'b0), 1'b0, '{default: '0}});
        plan.push_back('{make_frame(17'd4096, 32'sd6553600, 31'd0, 31'd0, 17'd0,
                                    32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0), 1'b0, '{default: '0}});
        plan.push_back('{make_frame(17'd0, 32'h7FFF_FFFF, 31'd65536, 31'd65536, 17'd0,
                                    32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0), 1'b0, '{default: '0}});
        // Brake just under two, and the smallest non-zero brake.
        plan.push_back('{make_frame(17'd65536, 32'sd65536000, 31'd6554, 31'd655360, 17'h1FFFF,
                                    32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0), 1'b0, '{default: '0}});
        plan.push_back('{make_frame(17'd2048, 32'sd6553600, 31'd65536, 31'd65536, 17'd1,
                                    32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0), 1'b0, '{default: '0}});
        // Smallest negative torque in reverse.
        plan.push_back('{make_frame(17'd65536, -32'sd1, 31'd65536, 31'd65536, 17'd0,
                                    32'h8000_0000, 1'b1, 1'b1, 1'b0), 1'b0, '{default: '0}});

        // Hold reset, then release it.
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            send_frame(plan[i].frm, plan[i].typed, plan[i].want);
        end

        // Random frames under each register setting; the third runs without idling.
        for (int set = 0; set < NUM_SETTINGS; set++)
        begin
            if (set > 0)
            begin
                in_valid <= 1'b0;
                while (spin_results_due.size() != 0)
                begin
                    @(posedge clk);
                end
                case (set)
                    1: program_registers('0, '0, '0, '0, '0);
                    2: program_registers(REG_MAX, REG_MAX, REG_MAX, REG_MAX, REG_MAX);
                    3: program_registers(31'($urandom_range(1 << 24)),
                                         31'($urandom_range(1 << 28)),
                                         31'($urandom_range(1 << 27)),
                                         31'($urandom_range(1 << 30)),
                                         31'($urandom_range(1 << 24)));
                    default: program_registers(31'($urandom), 31'($urandom), 31'($urandom),
                                               31'($urandom), 31'($urandom));
                endcase
            end
            calm = (set == 2);
            repeat (FRAMES_PER_SET)
            begin
                send_frame(random_frame(), 1'b0, '{default: '0});
            end
        end
        in_valid <= 1'b0;
        calm = 1'b0;

        // Drain, then allow for any stray result.
        while (spin_results_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d wheel frames under %0d register settings (%0d register writes).",
                 frames_sent, NUM_SETTINGS, reg_writes);
        $display("Checked %0d results; %0d field mismatches.", results_checked, failures);
        if (failures == 0)
        begin
            $display("tb_top passed");
        end
        else
        begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/wsi_pkg.sv
sv/wsi_mul.sv
sv/wsi_seq.sv
sv/wheel_spin_integrator_core.sv
dv/tb_top.sv
